// ===== src/drct_pkg.sv =====
// ----------------------------------------------------------------------------
// drct_pkg: shared types and constants of the dirty range counter tracker
// Sizes of the counter ring, operation codes, register indexes and the
// control bundle handed from the sequencer to the per-entry update unit.
// ----------------------------------------------------------------------------
package drct_pkg;

  // Ring size and counter width
  localparam int ENTRIES       = 1024;
  localparam int COUNTER_WIDTH = 8;

  // Widths derived from the ring size
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int LEN_W = $clog2(ENTRIES + 1);

  // Fixed field widths of the ports
  localparam int OP_W     = 3;
  localparam int FIELD_W  = 11;
  localparam int SETVAL_W = 8;
  localparam int CFG_W    = 11;
  localparam int OFFSET_W = 10;
  localparam int RLEN_W   = 11;

  // Working width for range arithmetic: holds a sum of two fields and the length
  localparam int WK_W = ((LEN_W > FIELD_W) ? LEN_W : FIELD_W) + 1;

  // Stream payload widths, padded to whole bytes
  localparam int IN_BITS   = OP_W + 2 * FIELD_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 1 + OFFSET_W + RLEN_W + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_SET_RANGE = 3'd0,
    OP_DEC_RANGE = 3'd1,
    OP_SET_ALL   = 3'd2,
    OP_CLEAR_ALL = 3'd3,
    OP_RECOMPUTE = 3'd4,
    OP_FIND_RUN  = 3'd5,
    OP_RSVD6     = 3'd6,
    OP_RSVD7     = 3'd7
  } op_e;

  // Configuration register indexes
  typedef enum logic {
    REG_SET_VALUE     = 1'b0,
    REG_ACTIVE_LENGTH = 1'b1
  } reg_e;

  // Sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  // Control handed to the update unit for the entry at the ring head
  typedef struct packed {
    op_e                      op;
    logic                     in_range;
    logic                     in_active;
    logic [COUNTER_WIDTH-1:0] set_val;
  } upd_ctl_t;

endpackage

// ===== src/drct_cell.sv =====
// ----------------------------------------------------------------------------
// drct_cell: one counter cell of the ring
// Holds one counter and takes its neighbor's value on every shift cycle.
// ----------------------------------------------------------------------------
module drct_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               shift_i,
  input  logic [drct_pkg::COUNTER_WIDTH-1:0] d_i,
  output logic [drct_pkg::COUNTER_WIDTH-1:0] q_o
);
  import drct_pkg::*;

  logic [COUNTER_WIDTH-1:0] cnt_q;

  // Take the neighbor's counter while the ring turns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (shift_i) begin
      cnt_q <= d_i;
    end
  end

  assign q_o = cnt_q;

endmodule

// ===== src/drct_update.sv =====
// ----------------------------------------------------------------------------
// drct_update: per-entry update unit
// Applies the current operation to the counter leaving the ring head and
// reports whether the entry counts toward the pending flag.
// ----------------------------------------------------------------------------
module drct_update (
  input  drct_pkg::upd_ctl_t                 ctl_i,
  input  logic [drct_pkg::COUNTER_WIDTH-1:0] val_i,
  output logic [drct_pkg::COUNTER_WIDTH-1:0] val_o,
  output logic                               hit_o
);
  import drct_pkg::*;

  logic [COUNTER_WIDTH-1:0] dec_val;

  // Count down, stopping at zero
  assign dec_val = (val_i != '0) ? val_i - COUNTER_WIDTH'(1) : '0;

  // Select the new counter value and the flag contribution
  always_comb begin
    val_o = val_i;
    hit_o = 1'b0;
    case (ctl_i.op)
      OP_SET_RANGE: begin
        if (ctl_i.in_range) val_o = ctl_i.set_val;
      end
      OP_DEC_RANGE: begin
        if (ctl_i.in_range) begin
          val_o = dec_val;
          hit_o = (dec_val != '0);
        end
      end
      OP_SET_ALL: begin
        if (ctl_i.in_active) val_o = ctl_i.set_val;
      end
      OP_CLEAR_ALL: begin
        if (ctl_i.in_active) val_o = '0;
      end
      OP_RECOMPUTE: begin
        hit_o = ctl_i.in_active && (val_i != '0);
      end
      default: begin
        val_o = val_i;
        hit_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/dirty_range_counter_tracker.sv =====
// ----------------------------------------------------------------------------
// dirty_range_counter_tracker: pending-update counters with run search
// Keeps one small counter per buffer entry in a ring of cells plus a pending
// flag, and applies range set, range decrement, set all, clear all, flag
// recompute and next-run search operations.
//
// Usage:
//   Operations arrive on the s_axis channel (one transfer per operation) and
//   each produces exactly one result transfer on m_axis.
//   Every operation turns the ring once, passing each of the ENTRIES (1024)
//   counters through the update unit at the ring head; the operation is
//   latched on acceptance and the result register is loaded after the turn.
//   A new operation is taken once the ring has finished its turn, while an
//   earlier result may still wait on m_axis.
//   When m_axis stalls and the result register is full, the finished
//   operation holds its result and s_axis_tready stays low until it drains.
//   Configuration writes (set value, active length) go through cfg_we_i and
//   take effect on the next accepted operation; write them only while idle.
//   Reset clears all counters and the pending flag at once, loads set value
//   1 and active length 1024; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dirty_range_counter_tracker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Operation stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [2:0] operation, [13:3] range_start, [24:14] range_count
  input  logic [drct_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // Result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] run_found, [10:1] run_offset, [21:11] run_length, [22] pending
  output logic [drct_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic                             cfg_addr_i,
  input  logic [drct_pkg::CFG_W-1:0]       cfg_data_i
);
  import drct_pkg::*;

  // Configuration registers
  logic [SETVAL_W-1:0] set_value_q;
  logic [CFG_W-1:0]    active_len_q;

  // Sequencer
  state_e              state_q, state_d;
  op_e                 op_q;
  logic [WK_W-1:0]     lo_q, hi_q, start_q, len_q;
  logic [LEN_W-1:0]    cnt_q;
  logic                acc_q;
  logic                found_q, open_q;
  logic [IDX_W-1:0]    off_q;
  logic [LEN_W-1:0]    rlen_q;
  logic                pending_q;

  // Result register
  logic                out_valid_q;
  logic                out_found_q;
  logic [OFFSET_W-1:0] out_off_q;
  logic [RLEN_W-1:0]   out_len_q;
  logic                out_pend_q;

  // Ring
  logic [COUNTER_WIDTH-1:0] ring [ENTRIES];
  logic [COUNTER_WIDTH-1:0] head_new;
  logic                     hit;
  logic                     shift;
  upd_ctl_t                 ctl;

  // Input fields and derived range
  logic                in_xfer;
  op_e                 in_op;
  logic [WK_W-1:0]     in_start, in_end, live_len, clip_lo, clip_end, clip_hi;
  logic [WK_W-1:0]     idx_w;
  logic                ring_done, finish, in_window, head_nz;
  logic                pend_new;
  logic [SETVAL_W+COUNTER_WIDTH-1:0] set_ext;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign in_op    = op_e'(s_axis_tdata[OP_W-1:0]);
  assign in_start = WK_W'(s_axis_tdata[OP_W +: FIELD_W]);
  assign in_end   = in_start + WK_W'(s_axis_tdata[OP_W+FIELD_W +: FIELD_W]);

  // Clip the range to the live length
  assign live_len = (WK_W'(active_len_q) > WK_W'(ENTRIES)) ? WK_W'(ENTRIES)
                                                           : WK_W'(active_len_q);
  assign clip_lo  = (in_start > live_len) ? live_len : in_start;
  assign clip_end = (in_end > live_len) ? live_len : in_end;
  assign clip_hi  = (clip_end < clip_lo) ? clip_lo : clip_end;

  // Position of the entry at the ring head
  assign idx_w     = WK_W'(cnt_q);
  assign ring_done = (cnt_q == LEN_W'(ENTRIES));
  assign shift     = (state_q == ST_RUN) && !ring_done;
  assign finish    = (state_q == ST_RUN) && ring_done && (!out_valid_q || m_axis_tready);

  // Control for the update unit
  assign set_ext      = {{COUNTER_WIDTH{1'b0}}, set_value_q};
  assign ctl.op       = op_q;
  assign ctl.in_range = (idx_w >= lo_q) && (idx_w < hi_q);
  assign ctl.in_active = (idx_w < len_q);
  assign ctl.set_val  = set_ext[COUNTER_WIDTH-1:0];

  assign in_window = (idx_w >= start_q) && (idx_w < len_q);
  assign head_nz   = (ring[0] != '0);

  drct_update u_update (
    .ctl_i (ctl),
    .val_i (ring[0]),
    .val_o (head_new),
    .hit_o (hit)
  );

  // Chain of counter cells; the head feeds back through the update unit
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    logic [COUNTER_WIDTH-1:0] cell_d;
    if (k == ENTRIES - 1) begin : g_tail
      assign cell_d = head_new;
    end else begin : g_mid
      assign cell_d = ring[k+1];
    end
    drct_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .d_i     (cell_d),
      .q_o     (ring[k])
    );
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_value_q  <= SETVAL_W'(1);
      active_len_q <= CFG_W'(1024);
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_addr_i))
        REG_SET_VALUE:     set_value_q  <= cfg_data_i[SETVAL_W-1:0];
        REG_ACTIVE_LENGTH: active_len_q <= cfg_data_i;
        default:           set_value_q  <= set_value_q;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_RUN;
      ST_RUN:  if (finish) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Flag after the operation
  always_comb begin
    case (op_q)
      OP_SET_RANGE, OP_SET_ALL: pend_new = 1'b1;
      OP_DEC_RANGE:             pend_new = pending_q | acc_q;
      OP_CLEAR_ALL:             pend_new = 1'b0;
      OP_RECOMPUTE:             pend_new = pending_q & acc_q;
      default:                  pend_new = pending_q;
    endcase
  end

  // Latch the operation, walk the ring and track the run search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      acc_q     <= 1'b0;
      found_q   <= 1'b0;
      open_q    <= 1'b0;
      pending_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        cnt_q   <= '0;
        acc_q   <= 1'b0;
        found_q <= 1'b0;
        open_q  <= 1'b0;
      end else if (shift) begin
        cnt_q <= cnt_q + LEN_W'(1);
        if (hit) acc_q <= 1'b1;
        if (op_q == OP_FIND_RUN && in_window) begin
          if (head_nz && !found_q) begin
            found_q <= 1'b1;
            open_q  <= 1'b1;
          end else if (!head_nz) begin
            open_q <= 1'b0;
          end
        end
      end
      if (finish) pending_q <= pend_new;
    end
  end

  // Operation payload and run position
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= in_op;
      lo_q    <= clip_lo;
      hi_q    <= clip_hi;
      start_q <= in_start;
      len_q   <= live_len;
      off_q   <= '0;
      rlen_q  <= '0;
    end else if (shift && op_q == OP_FIND_RUN && in_window && head_nz) begin
      if (!found_q) begin
        off_q  <= cnt_q[IDX_W-1:0];
        rlen_q <= LEN_W'(1);
      end else if (open_q) begin
        rlen_q <= rlen_q + LEN_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  logic [WK_W-1:0] off_ext, rlen_ext;
  assign off_ext  = WK_W'(off_q);
  assign rlen_ext = WK_W'(rlen_q);

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_found_q <= found_q;
      out_off_q   <= off_ext[OFFSET_W-1:0];
      out_len_q   <= rlen_ext[RLEN_W-1:0];
      out_pend_q  <= pend_new;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}},
                          out_pend_q, out_len_q, out_off_q, out_found_q};

endmodule
